// ===== src/pvfc_pkg.sv =====
// Package with the shared types and constants of the flow classifier.
`timescale 1ns / 1ps

package pvfc_pkg;

    // Flow table geometry.
    localparam int FLOW_SLOTS = 1024;
    localparam int SLOT_W     = $clog2(FLOW_SLOTS);

    // Payload signatures, first byte in the most significant bits.
    localparam logic [31:0] SIG_A = 32'hE903_4101;
    localparam logic [31:0] SIG_B = 32'hE903_4201;
    localparam logic [31:0] SIG_C = 32'h1C1C_3201;

    // Lengths and ports that the matchers look for.
    localparam logic [15:0] LEN_SIG_B     = 16'd57;
    localparam logic [15:0] LEN_PORT_REQ  = 16'd94;
    localparam logic [15:0] LEN_PORT_REP  = 16'd49;
    localparam logic [15:0] MIN_PREFIX    = 16'd4;
    localparam logic [15:0] PORT_ONE      = 16'd5041;
    localparam logic [15:0] PORT_TWO      = 16'd8303;

    // Reset value of the packet limit register.
    localparam logic [7:0] PACKET_LIMIT_RST = 8'd20;

    // Verdict codes.
    typedef enum logic [1:0] {
        VERDICT_UNDECIDED = 2'd0,
        VERDICT_DETECTED  = 2'd1,
        VERDICT_EXCLUDED  = 2'd2
    } verdict_t;

    // Per-flow record as held in the table.
    typedef struct packed {
        logic       det;
        logic [1:0] stage_c;
        logic [1:0] stage_b;
        logic [2:0] stage_a;
    } flow_rec_t;

    // One packet descriptor as the matcher sees it.
    typedef struct packed {
        logic        direction;
        logic [15:0] payload_length;
        logic [31:0] first_bytes;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  packet_count;
    } pkt_desc_t;

endpackage

// ===== src/p2p_video_flow_classifier.sv =====
// Top level of the per-flow UDP classifier: table pipeline and output register.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid, in_stall) carries one packet descriptor per
// transfer: flow slot, new-flow mark, direction, payload length, first four
// payload bytes, ports and packet count. The output channel (out_valid,
// out_stall) returns one verdict per descriptor, in order.
// The packet limit register is written through cfg_write_en/cfg_write_data
// only while the block is idle, a rule the user must keep, which the block
// does not enforce; it resets to 20. A descriptor's record is read from
// the flow table in the cycle of acceptance; its verdict is registered in the
// output register. Throughput is one descriptor per cycle without stalls;
// the record is written back as the update ends, and a bypass register
// forwards the last written record to back-to-back packets of one flow.
// When the receiver stalls, the verdict holds in the output register; one
// more descriptor can still be taken into the update stage, after which
// in_stall rises until the output register drains.
// Reset clears the pipeline valid bits and the bypass, and restores the
// limit. The flow table itself is not cleared: each flow starts with a
// descriptor that has new_flow set.
module p2p_video_flow_classifier (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [7:0]             cfg_write_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [pvfc_pkg::SLOT_W-1:0] flow_slot,
    input  logic                   new_flow,
    input  logic                   direction,
    input  logic [15:0]            payload_length,
    input  logic [31:0]            first_bytes,
    input  logic [15:0]            source_port,
    input  logic [15:0]            dest_port,
    input  logic [7:0]             packet_count,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             verdict
);
    import pvfc_pkg::*;

    logic              in_accept;
    logic              out_ready;
    logic              s1_fire;
    logic              s1_valid_reg;
    logic              s1_new_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    pkt_desc_t         s1_pkt_reg;
    logic              byp_valid_reg;
    logic [SLOT_W-1:0] byp_slot_reg;
    flow_rec_t         byp_rec_reg;
    flow_rec_t         rd_rec;
    flow_rec_t         rec_mem;
    flow_rec_t         rec_cur;
    flow_rec_t         rec_next;
    verdict_t          verdict_next;
    logic [7:0]        packet_limit_reg;
    logic              out_valid_reg;
    verdict_t          verdict_reg;

    // Handshake control.
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && out_ready;
    assign in_stall  = s1_valid_reg && !out_ready;
    assign in_accept = in_valid && !in_stall;

    // Packet limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_limit_reg <= PACKET_LIMIT_RST;
        end
        else if (cfg_write_en)
        begin
            packet_limit_reg <= cfg_write_data;
        end
    end

    // Flow table.
    pvfc_flow_ram u_flow_ram (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_slot_reg),
        .wr_data (rec_next),
        .rd_en   (in_accept),
        .rd_addr (flow_slot),
        .rd_data (rd_rec)
    );

    // Update stage valid bit and bypass control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                byp_valid_reg <= 1'b1;
            end
        end
    end

    // Update stage payload and the last record written.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_slot_reg              <= flow_slot;
            s1_new_reg               <= new_flow;
            s1_pkt_reg.direction     <= direction;
            s1_pkt_reg.payload_length <= payload_length;
            s1_pkt_reg.first_bytes   <= first_bytes;
            s1_pkt_reg.source_port   <= source_port;
            s1_pkt_reg.dest_port     <= dest_port;
            s1_pkt_reg.packet_count  <= packet_count;
        end
        if (s1_fire)
        begin
            byp_slot_reg <= s1_slot_reg;
            byp_rec_reg  <= rec_next;
        end
    end

    // The bypass holds the newest write of its slot, so it wins over the table.
    assign rec_mem = (byp_valid_reg && (byp_slot_reg == s1_slot_reg)) ? byp_rec_reg : rd_rec;
    assign rec_cur = s1_new_reg ? flow_rec_t'('0) : rec_mem;

    pvfc_match u_match (
        .rec          (rec_cur),
        .pkt          (s1_pkt_reg),
        .packet_limit (packet_limit_reg),
        .rec_next     (rec_next),
        .verdict      (verdict_next)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

`ifndef SYNTHESIS
    // Input is held off only while the update stage is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("in_stall raised with an empty update stage");

    // A finished update always lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("update completed but no verdict presented");

    // An excluded packet leaves its record as it was read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && verdict_next == VERDICT_EXCLUDED) |-> (rec_next == rec_cur))
        else $error("excluded packet changed its flow record");

    // A detected flow never falls back to undecided within one update.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && rec_cur.det) |-> (verdict_next != VERDICT_UNDECIDED))
        else $error("detected flow reported as undecided");

    // The bypass is taken only once a record has been written.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && !byp_valid_reg) |=> byp_valid_reg)
        else $error("bypass not armed after first write");
`endif

endmodule

// ===== src/pvfc_flow_ram.sv =====
// Flow record memory: one write port and one registered read port.
`timescale 1ns / 1ps

module pvfc_flow_ram (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [pvfc_pkg::SLOT_W-1:0] wr_addr,
    input  pvfc_pkg::flow_rec_t    wr_data,
    input  logic                   rd_en,
    input  logic [pvfc_pkg::SLOT_W-1:0] rd_addr,
    output pvfc_pkg::flow_rec_t    rd_data
);
    import pvfc_pkg::*;

    flow_rec_t mem_reg [FLOW_SLOTS];
    flow_rec_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; a read at the address being written returns the old data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/pvfc_match.sv =====
// Record update and verdict for one packet: limit check and three matchers.
`timescale 1ns / 1ps

module pvfc_match (
    input  pvfc_pkg::flow_rec_t rec,
    input  pvfc_pkg::pkt_desc_t pkt,
    input  logic [7:0]          packet_limit,
    output pvfc_pkg::flow_rec_t rec_next,
    output pvfc_pkg::verdict_t  verdict
);
    import pvfc_pkg::*;

    logic       prefix_ok;
    logic       pa;
    logic       pb;
    logic       pc;
    logic       excluded;
    logic       port_hit;
    logic       a_reply;
    logic       a_hit;
    logic       b_reply;
    logic       c_reply;
    logic       det_a;
    logic       det_b;
    logic       det_c;
    logic [2:0] sa_new;
    logic [1:0] sb_new;
    logic [1:0] sc_new;

    // Signature prefixes need at least four payload bytes.
    assign prefix_ok = (pkt.payload_length >= MIN_PREFIX);
    assign pa = prefix_ok && (pkt.first_bytes == SIG_A);
    assign pb = prefix_ok && (pkt.first_bytes == SIG_B);
    assign pc = prefix_ok && (pkt.first_bytes == SIG_C);

    assign excluded = (pkt.packet_count > packet_limit);
    assign port_hit = (pkt.dest_port == PORT_ONE) || (pkt.source_port == PORT_ONE) ||
                      (pkt.dest_port == PORT_TWO) || (pkt.source_port == PORT_TWO);

    // Matcher A. Odd stages hold a request seen in direction 0, even ones in
    // direction 1, so a reply is a packet whose direction equals bit 0.
    assign a_reply = (rec.stage_a != 3'd0) && (rec.stage_a != 3'd7) &&
                     (rec.stage_a[0] == pkt.direction);
    always_comb
    begin
        if (rec.stage_a <= 3'd2)
        begin
            a_hit = pa || pb;
        end
        else if (rec.stage_a <= 3'd4)
        begin
            a_hit = pa;
        end
        else
        begin
            a_hit = pc;
        end
    end

    always_comb
    begin
        sa_new = rec.stage_a;
        det_a  = 1'b0;
        if (rec.stage_a == 3'd0)
        begin
            if (pa)
            begin
                sa_new = 3'd1 + {2'b00, pkt.direction};
            end
            else if (pb)
            begin
                sa_new = 3'd3 + {2'b00, pkt.direction};
            end
            else if (pc)
            begin
                sa_new = 3'd5 + {2'b00, pkt.direction};
            end
        end
        else if (a_reply)
        begin
            if (a_hit)
            begin
                det_a = 1'b1;
            end
            else
            begin
                sa_new = 3'd0;
            end
        end
    end

    // Matcher B: a stage of 3 never counts as the request direction.
    assign b_reply = !((rec.stage_b == 2'd1 && !pkt.direction) ||
                       (rec.stage_b == 2'd2 && pkt.direction));
    always_comb
    begin
        sb_new = rec.stage_b;
        det_b  = 1'b0;
        if (!det_a)
        begin
            if (rec.stage_b == 2'd0)
            begin
                if (pkt.payload_length == LEN_SIG_B && pa)
                begin
                    sb_new = 2'd1 + {1'b0, pkt.direction};
                end
            end
            else if (b_reply)
            begin
                if (pkt.payload_length == 16'd0)
                begin
                    det_b = 1'b1;
                end
                else
                begin
                    sb_new = 2'd0;
                end
            end
        end
    end

    // Matcher C: the port based request and its reply lengths.
    assign c_reply = !((rec.stage_c == 2'd1 && !pkt.direction) ||
                       (rec.stage_c == 2'd2 && pkt.direction));
    always_comb
    begin
        sc_new = rec.stage_c;
        det_c  = 1'b0;
        if (!det_a && !det_b)
        begin
            if (rec.stage_c == 2'd0)
            begin
                if (pkt.payload_length == LEN_PORT_REQ && port_hit)
                begin
                    sc_new = 2'd1 + {1'b0, pkt.direction};
                end
            end
            else if (c_reply)
            begin
                if (pkt.payload_length == 16'd0 || pkt.payload_length == LEN_PORT_REP ||
                    pkt.payload_length == LEN_PORT_REQ)
                begin
                    det_c = 1'b1;
                end
                else
                begin
                    sc_new = 2'd0;
                end
            end
        end
    end

    // Limit first, then a flow already detected, then the matchers.
    always_comb
    begin
        if (excluded)
        begin
            rec_next = rec;
            verdict  = VERDICT_EXCLUDED;
        end
        else if (rec.det)
        begin
            rec_next = rec;
            verdict  = VERDICT_DETECTED;
        end
        else
        begin
            rec_next.det     = det_a || det_b || det_c;
            rec_next.stage_c = sc_new;
            rec_next.stage_b = sb_new;
            rec_next.stage_a = sa_new;
            verdict = (det_a || det_b || det_c) ? VERDICT_DETECTED : VERDICT_UNDECIDED;
        end
    end

endmodule
